[hdl/lhist_pkg.sv]
package lhist_pkg;

	localparam int STAMP_W = 64;
	localparam int COUNT_W = 32;
	localparam int CFG_W   = 16;
	localparam int BIN_COUNT = 32;
	localparam int BIN_W   = $clog2(BIN_COUNT);
	localparam int MODULE_ID_W = 2;
	localparam int POINT_ID_W  = 4;
	localparam int DIV_CNT_W   = $clog2(STAMP_W);

	localparam int MODULE_COUNT_DEF = 4;
	localparam int POINT_COUNT_DEF  = 16;

	localparam logic [CFG_W-1:0] CYCLES_PER_US_RESET = 16'd1000;

	// quotients above 31 bits saturate to 0x7FFFFFFF, whose top bit lands in this bin
	localparam logic [DIV_CNT_W-1:0] SAT_BIN = DIV_CNT_W'(30);

	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_READ   = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIVIDE,
		ST_READ,
		ST_UPDATE
	} lhist_state_t;

endpackage

[hdl/log2_latency_histogram_unit.sv]
// Latency histogram with power-of-two bins, kept per module and per point.
// After reset a clearing pass runs over all counters, through MODULE_COUNT *
// POINT_COUNT * 32 bin addresses (2048 at the defaults), with busy high; config
// writes are taken during it. A command is taken when start is high and busy is
// low. A record divides (end_stamp - start_stamp) by cycles_per_us with a
// restoring divider that yields one quotient bit per cycle, so a record keeps
// busy high through 64 divide steps, one memory read and one update. A read, a
// reversed record or an out-of-range module/point goes straight to the memory
// read and update. Each result is shown for one cycle with done high, in the cycle
// busy falls; the receiver cannot stall it. A cycles_per_us of 0 divides by 1.
module log2_latency_histogram_unit #(
	parameter int MODULE_COUNT = lhist_pkg::MODULE_COUNT_DEF,
	parameter int POINT_COUNT  = lhist_pkg::POINT_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [lhist_pkg::CFG_W-1:0]         cfg_wr_data,
	input  logic                                start,
	output logic                                busy,
	input  logic                                operation,
	input  logic [lhist_pkg::MODULE_ID_W-1:0]   module_id,
	input  logic [lhist_pkg::POINT_ID_W-1:0]    point_id,
	input  logic [lhist_pkg::STAMP_W-1:0]       start_stamp,
	input  logic [lhist_pkg::STAMP_W-1:0]       end_stamp,
	input  logic [lhist_pkg::BIN_W-1:0]         read_bin,
	output logic                                done,
	output logic [lhist_pkg::BIN_W-1:0]         bin_index,
	output logic [lhist_pkg::COUNT_W-1:0]       bin_count,
	output logic [lhist_pkg::COUNT_W-1:0]       request_total,
	output logic [lhist_pkg::COUNT_W-1:0]       reversed_total,
	output logic                                was_reversed
);

	localparam int SLOT_CNT  = MODULE_COUNT * POINT_COUNT;
	localparam int SLOT_W    = (SLOT_CNT > 1) ? $clog2(SLOT_CNT) : 1;
	localparam int ADDR_W    = SLOT_W + lhist_pkg::BIN_W;
	localparam int BIN_DEPTH = SLOT_CNT * lhist_pkg::BIN_COUNT;
	localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(BIN_DEPTH - 1);
	localparam int STAMP_W   = lhist_pkg::STAMP_W;
	localparam int COUNT_W   = lhist_pkg::COUNT_W;
	localparam int CFG_W     = lhist_pkg::CFG_W;
	localparam int BIN_W     = lhist_pkg::BIN_W;
	localparam int DIV_CNT_W = lhist_pkg::DIV_CNT_W;

	lhist_pkg::lhist_state_t state_q, state_d;

	logic [CFG_W-1:0]     cycles_per_us_q;
	logic [CFG_W-1:0]     divisor_q;
	logic [ADDR_W-1:0]    clr_q;
	logic                 op_q;
	logic                 oor_q;
	logic                 rev_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [BIN_W-1:0]     read_bin_q;
	logic [BIN_W-1:0]     bin_q;
	logic [STAMP_W-1:0]   dvd_q;
	logic [CFG_W-1:0]     rem_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 found_q;
	logic [DIV_CNT_W-1:0] pos_q;
	logic                 done_q;

	logic [BIN_W-1:0]   bin_index_q;
	logic [COUNT_W-1:0] bin_count_q;
	logic [COUNT_W-1:0] request_total_q;
	logic [COUNT_W-1:0] reversed_total_q;
	logic               was_reversed_q;

	logic [COUNT_W-1:0] bin_mem [BIN_DEPTH];
	logic [COUNT_W-1:0] req_mem [SLOT_CNT];
	logic [COUNT_W-1:0] rev_mem [SLOT_CNT];
	logic [COUNT_W-1:0] bin_rd_q;
	logic [COUNT_W-1:0] req_rd_q;
	logic [COUNT_W-1:0] rev_rd_q;

	logic                 accept;
	logic                 in_range;
	logic                 reversed_now;
	logic [SLOT_W-1:0]    slot_now;
	logic [CFG_W+1:0]     trial;
	logic                 qbit;
	logic [BIN_W-1:0]     bin_sel;
	logic                 clearing;
	logic                 updating;
	logic                 bin_we;
	logic                 req_we;
	logic                 rev_we;
	logic [ADDR_W-1:0]    bin_waddr;
	logic [SLOT_W-1:0]    slot_waddr;
	logic [COUNT_W-1:0]   bin_wdata;
	logic [COUNT_W-1:0]   req_wdata;
	logic [COUNT_W-1:0]   rev_wdata;
	logic [COUNT_W-1:0]   bin_inc;
	logic [COUNT_W-1:0]   req_inc;
	logic [COUNT_W-1:0]   rev_inc;

	assign busy   = (state_q != lhist_pkg::ST_IDLE);
	assign accept = start && !busy;

	assign in_range = (int'(module_id) < MODULE_COUNT) && (int'(point_id) < POINT_COUNT);
	assign slot_now = SLOT_W'(int'(module_id) * POINT_COUNT + int'(point_id));
	assign reversed_now = (end_stamp < start_stamp);

	// one restoring step: shift in the next dividend bit, try to subtract
	assign trial = {1'b0, rem_q, dvd_q[STAMP_W-1]} - {2'b00, divisor_q};
	assign qbit  = !trial[CFG_W+1];

	always_comb begin
		if (op_q == lhist_pkg::OP_READ) begin
			bin_sel = read_bin_q;
		end else if (rev_q || !found_q) begin
			bin_sel = '0;
		end else if (pos_q >= lhist_pkg::SAT_BIN) begin
			bin_sel = BIN_W'(lhist_pkg::SAT_BIN);
		end else begin
			bin_sel = pos_q[BIN_W-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lhist_pkg::ST_CLEAR: begin
				if (clr_q == CLR_LAST) state_d = lhist_pkg::ST_IDLE;
			end
			lhist_pkg::ST_IDLE: begin
				if (start) begin
					if (in_range && operation == lhist_pkg::OP_RECORD && !reversed_now)
						state_d = lhist_pkg::ST_DIVIDE;
					else
						state_d = lhist_pkg::ST_READ;
				end
			end
			lhist_pkg::ST_DIVIDE: begin
				if (div_cnt_q == '0) state_d = lhist_pkg::ST_READ;
			end
			lhist_pkg::ST_READ: begin
				state_d = lhist_pkg::ST_UPDATE;
			end
			lhist_pkg::ST_UPDATE: begin
				state_d = lhist_pkg::ST_IDLE;
			end
			default: begin
				state_d = lhist_pkg::ST_CLEAR;
			end
		endcase
	end

	// memory write controls
	always_comb begin
		clearing = 1'b0;
		updating = 1'b0;
		case (state_q)
			lhist_pkg::ST_CLEAR:  clearing = 1'b1;
			lhist_pkg::ST_UPDATE: updating = 1'b1;
			default: begin
				clearing = 1'b0;
				updating = 1'b0;
			end
		endcase
	end

	assign bin_inc = bin_rd_q + COUNT_W'(1);
	assign req_inc = req_rd_q + COUNT_W'(1);
	assign rev_inc = rev_rd_q + COUNT_W'(1);

	assign bin_we = clearing || (updating && !oor_q && op_q == lhist_pkg::OP_RECORD && !rev_q);
	assign req_we = clearing || (updating && !oor_q && op_q == lhist_pkg::OP_RECORD);
	assign rev_we = clearing || (updating && !oor_q && op_q == lhist_pkg::OP_RECORD && rev_q);

	assign bin_waddr  = clearing ? clr_q : {slot_q, bin_q};
	assign slot_waddr = clearing ? clr_q[ADDR_W-1 -: SLOT_W] : slot_q;
	assign bin_wdata  = clearing ? '0 : bin_inc;
	assign req_wdata  = clearing ? '0 : req_inc;
	assign rev_wdata  = clearing ? '0 : rev_inc;

	always_ff @(posedge clk) begin
		if (bin_we) bin_mem[bin_waddr] <= bin_wdata;
		if (req_we) req_mem[slot_waddr] <= req_wdata;
		if (rev_we) rev_mem[slot_waddr] <= rev_wdata;
		bin_rd_q <= bin_mem[{slot_q, bin_sel}];
		req_rd_q <= req_mem[slot_q];
		rev_rd_q <= rev_mem[slot_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= lhist_pkg::ST_CLEAR;
			cycles_per_us_q <= lhist_pkg::CYCLES_PER_US_RESET;
			clr_q           <= '0;
			done_q          <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= updating;
			if (cfg_wr_en) cycles_per_us_q <= cfg_wr_data;
			if (clearing) clr_q <= clr_q + ADDR_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= operation;
			oor_q      <= !in_range;
			rev_q      <= reversed_now;
			slot_q     <= in_range ? slot_now : '0;
			read_bin_q <= read_bin;
			dvd_q      <= end_stamp - start_stamp;
			rem_q      <= '0;
			div_cnt_q  <= DIV_CNT_W'(STAMP_W - 1);
			found_q    <= 1'b0;
			pos_q      <= '0;
			divisor_q  <= (cycles_per_us_q == '0) ? CFG_W'(1) : cycles_per_us_q;
		end else if (state_q == lhist_pkg::ST_DIVIDE) begin
			dvd_q     <= {dvd_q[STAMP_W-2:0], 1'b0};
			rem_q     <= qbit ? trial[CFG_W-1:0] : {rem_q[CFG_W-2:0], dvd_q[STAMP_W-1]};
			div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
			// quotient comes out MSB first: remember where its top bit sits
			if (qbit && !found_q) begin
				found_q <= 1'b1;
				pos_q   <= div_cnt_q;
			end
		end
		if (state_q == lhist_pkg::ST_READ) bin_q <= bin_sel;
		if (updating) begin
			if (oor_q) begin
				bin_index_q      <= '0;
				bin_count_q      <= '0;
				request_total_q  <= '0;
				reversed_total_q <= '0;
				was_reversed_q   <= 1'b0;
			end else if (op_q == lhist_pkg::OP_READ) begin
				bin_index_q      <= bin_q;
				bin_count_q      <= bin_rd_q;
				request_total_q  <= req_rd_q;
				reversed_total_q <= rev_rd_q;
				was_reversed_q   <= 1'b0;
			end else begin
				bin_index_q      <= bin_q;
				bin_count_q      <= rev_q ? '0 : bin_inc;
				request_total_q  <= req_inc;
				reversed_total_q <= rev_q ? rev_inc : rev_rd_q;
				was_reversed_q   <= rev_q;
			end
		end
	end

	assign done           = done_q;
	assign bin_index      = bin_index_q;
	assign bin_count      = bin_count_q;
	assign request_total  = request_total_q;
	assign reversed_total = reversed_total_q;
	assign was_reversed   = was_reversed_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("command taken without going busy");

	a_reversed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && was_reversed |-> bin_index == '0 && bin_count == '0)
		else $error("reversed record reports a bin");

	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lhist_pkg::ST_CLEAR |-> busy && !done)
		else $error("clearing pass not guarded");

endmodule

[tb/sv/tb_log2_latency_histogram_unit.sv]
module tb_log2_latency_histogram_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MODULES = lhist_pkg::MODULE_COUNT_DEF;
	localparam int POINTS = lhist_pkg::POINT_COUNT_DEF;
	localparam int SLOTS = MODULES * POINTS;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int ITEMS_PER_PHASE = 285;
	localparam logic [lhist_pkg::STAMP_W-1:0] STAMP_MAX = '1;
	localparam logic [lhist_pkg::STAMP_W-1:0] SAT_QUOTIENT = 64'h7FFF_FFFF;
	localparam logic [5:0] HOT_SLOTS [4] = '{6'd0, 6'd21, 6'd42, 6'd63};

	typedef struct packed {
		logic                              operation;
		logic [lhist_pkg::MODULE_ID_W-1:0] module_id;
		logic [lhist_pkg::POINT_ID_W-1:0]  point_id;
		logic [lhist_pkg::STAMP_W-1:0]     start_stamp;
		logic [lhist_pkg::STAMP_W-1:0]     end_stamp;
		logic [lhist_pkg::BIN_W-1:0]       read_bin;
	} command_t;

	typedef struct packed {
		logic [lhist_pkg::BIN_W-1:0]   bin_index;
		logic [lhist_pkg::COUNT_W-1:0] bin_count;
		logic [lhist_pkg::COUNT_W-1:0] request_total;
		logic [lhist_pkg::COUNT_W-1:0] reversed_total;
		logic                          was_reversed;
	} tally_t;

	class histogram_scoreboard;
		logic [lhist_pkg::COUNT_W-1:0] bin_counts [SLOTS*lhist_pkg::BIN_COUNT];
		logic [lhist_pkg::COUNT_W-1:0] request_counts [SLOTS];
		logic [lhist_pkg::COUNT_W-1:0] reversed_counts [SLOTS];
		logic [lhist_pkg::CFG_W-1:0]   cycles_per_us;
		tally_t                        expected_tallies [$];
		int                            errors;

		function new();
			foreach (bin_counts[i]) bin_counts[i] = '0;
			foreach (request_counts[i]) begin
				request_counts[i] = '0;
				reversed_counts[i] = '0;
			end
			cycles_per_us = lhist_pkg::CYCLES_PER_US_RESET;
			errors = 0;
		endfunction

		function int pending();
			return expected_tallies.size();
		endfunction

		function void note_command(command_t cmd);
			int slot;
			int bin;
			logic [lhist_pkg::STAMP_W-1:0] divisor;
			logic [lhist_pkg::STAMP_W-1:0] quotient;
			tally_t t;
			slot = int'(cmd.module_id) * POINTS + int'(cmd.point_id);
			t = '0;
			if (cmd.operation == lhist_pkg::OP_RECORD) begin
				if (cmd.end_stamp >= cmd.start_stamp) begin
					divisor = (cycles_per_us == '0) ? 64'd1 :
						lhist_pkg::STAMP_W'(cycles_per_us);
					quotient = (cmd.end_stamp - cmd.start_stamp) / divisor;
					if (quotient > SAT_QUOTIENT)
						quotient = SAT_QUOTIENT;
					bin = 0;
					for (int b = 0; b < 31; b++)
						if (quotient[b]) bin = b;
					bin_counts[slot*lhist_pkg::BIN_COUNT + bin] += 1;
					t.bin_index = lhist_pkg::BIN_W'(bin);
					t.bin_count = bin_counts[slot*lhist_pkg::BIN_COUNT + bin];
				end else begin
					reversed_counts[slot] += 1;
					t.was_reversed = 1'b1;
				end
				request_counts[slot] += 1;
			end else begin
				t.bin_index = cmd.read_bin;
				t.bin_count = bin_counts[slot*lhist_pkg::BIN_COUNT + int'(cmd.read_bin)];
			end
			t.request_total = request_counts[slot];
			t.reversed_total = reversed_counts[slot];
			expected_tallies.push_back(t);
		endfunction

		function void compare(string field, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_result(tally_t got);
			tally_t want;
			if (expected_tallies.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual bin %0d count %0h",
					$time, got.bin_index, got.bin_count);
				errors++;
				return;
			end
			want = expected_tallies.pop_front();
			compare("bin_index", 64'(want.bin_index), 64'(got.bin_index));
			compare("bin_count", 64'(want.bin_count), 64'(got.bin_count));
			compare("request_total", 64'(want.request_total), 64'(got.request_total));
			compare("reversed_total", 64'(want.reversed_total), 64'(got.reversed_total));
			compare("was_reversed", 64'(want.was_reversed), 64'(got.was_reversed));
		endfunction
	endclass

	logic                              clk;
	logic                              arst_n;
	logic                              cfg_wr_en;
	logic [lhist_pkg::CFG_W-1:0]       cfg_wr_data;
	logic                              start;
	logic                              busy;
	logic                              operation;
	logic [lhist_pkg::MODULE_ID_W-1:0] module_id;
	logic [lhist_pkg::POINT_ID_W-1:0]  point_id;
	logic [lhist_pkg::STAMP_W-1:0]     start_stamp;
	logic [lhist_pkg::STAMP_W-1:0]     end_stamp;
	logic [lhist_pkg::BIN_W-1:0]       read_bin;
	logic                              done;
	logic [lhist_pkg::BIN_W-1:0]       bin_index;
	logic [lhist_pkg::COUNT_W-1:0]     bin_count;
	logic [lhist_pkg::COUNT_W-1:0]     request_total;
	logic [lhist_pkg::COUNT_W-1:0]     reversed_total;
	logic                              was_reversed;

	histogram_scoreboard ledger;
	int cycle_count = 0;

	log2_latency_histogram_unit dut (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_log2_latency_histogram_unit: FAIL");
			$finish;
		end
	end

	// results first: a beat accepted in the done cycle queues behind the one shown
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				ledger.check_result(tally_t'({bin_index, bin_count, request_total,
					reversed_total, was_reversed}));
			if (start && !busy)
				ledger.note_command(command_t'({operation, module_id, point_id,
					start_stamp, end_stamp, read_bin}));
		end
	end

	function automatic logic [lhist_pkg::STAMP_W-1:0] rand_stamp();
		return {$urandom, $urandom};
	endfunction

	function automatic command_t make_command(logic op, int mod, int pt,
		logic [lhist_pkg::STAMP_W-1:0] s, logic [lhist_pkg::STAMP_W-1:0] e, int rb);
		command_t cmd;
		cmd.operation = op;
		cmd.module_id = lhist_pkg::MODULE_ID_W'(mod);
		cmd.point_id = lhist_pkg::POINT_ID_W'(pt);
		cmd.start_stamp = s;
		cmd.end_stamp = e;
		cmd.read_bin = lhist_pkg::BIN_W'(rb);
		return cmd;
	endfunction

	function automatic command_t random_command();
		command_t cmd;
		logic [lhist_pkg::STAMP_W-1:0] span;
		logic [lhist_pkg::STAMP_W-1:0] room;
		logic [lhist_pkg::STAMP_W-1:0] a;
		logic [lhist_pkg::STAMP_W-1:0] b;
		int pick;
		cmd = make_command(lhist_pkg::OP_RECORD, $urandom, $urandom, rand_stamp(),
			rand_stamp(), $urandom);
		// crowd a few slots so their counters climb
		if ($urandom_range(0, 99) < 60)
			{cmd.module_id, cmd.point_id} = HOT_SLOTS[$urandom_range(0, 3)];
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			cmd.operation = lhist_pkg::OP_READ;
		end else if (pick < 35) begin
			a = rand_stamp();
			b = rand_stamp();
			cmd.start_stamp = (a > b) ? a : b;
			cmd.end_stamp = (a > b) ? b : a;
			if ($urandom_range(0, 3) == 0 && cmd.start_stamp != '0)
				cmd.end_stamp = cmd.start_stamp - 1;
		end else begin
			// spread the span over all magnitudes so every bin gets hit
			span = rand_stamp() >> $urandom_range(0, 63);
			room = ~span;
			if (cmd.start_stamp > room)
				cmd.start_stamp = rand_stamp() % (room + 1);
			cmd.end_stamp = cmd.start_stamp + span;
		end
		return cmd;
	endfunction

	task automatic issue(command_t cmd);
		start <= 1'b1;
		operation <= cmd.operation;
		module_id <= cmd.module_id;
		point_id <= cmd.point_id;
		start_stamp <= cmd.start_stamp;
		end_stamp <= cmd.end_stamp;
		read_bin <= cmd.read_bin;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic maybe_idle(bit allow);
		if (allow && $urandom_range(0, 99) < 7) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 80)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (ledger.pending() != 0) @(posedge clk);
	endtask

	task automatic write_divisor(logic [lhist_pkg::CFG_W-1:0] value);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		ledger.cycles_per_us = value;
	endtask

	initial begin
		logic [lhist_pkg::CFG_W-1:0] divisors [6];
		ledger = new();
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = lhist_pkg::CYCLES_PER_US_RESET;
		start = 1'b0;
		operation = lhist_pkg::OP_RECORD;
		module_id = '0;
		point_id = '0;
		start_stamp = '0;
		end_stamp = '0;
		read_bin = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset divisor of 1000
		issue(make_command(lhist_pkg::OP_RECORD, 0, 0, 64'd0, 64'd0, 0));
		issue(make_command(lhist_pkg::OP_RECORD, 0, 0, 64'd0, 64'd999, 0));
		issue(make_command(lhist_pkg::OP_RECORD, 0, 0, 64'd0, 64'd2000, 0));
		issue(make_command(lhist_pkg::OP_RECORD, 3, 15, STAMP_MAX, STAMP_MAX, 0));
		issue(make_command(lhist_pkg::OP_RECORD, 3, 15, STAMP_MAX, 64'd0, 0));
		issue(make_command(lhist_pkg::OP_RECORD, 0, 0, 64'd1, 64'd0, 0));
		issue(make_command(lhist_pkg::OP_READ, 0, 0, 64'd0, 64'd0, 0));
		issue(make_command(lhist_pkg::OP_READ, 3, 15, 64'd0, 64'd0, 31));
		issue(make_command(lhist_pkg::OP_READ, 0, 0, 64'd0, 64'd0, 1));

		// divide by one: quotients beyond 31 bits saturate
		write_divisor(16'd1);
		issue(make_command(lhist_pkg::OP_RECORD, 1, 5, 64'd0, STAMP_MAX, 0));
		issue(make_command(lhist_pkg::OP_RECORD, 1, 5, 64'd0, 64'h7FFF_FFFF, 0));
		issue(make_command(lhist_pkg::OP_RECORD, 1, 5, 64'd1, 64'h8000_0001, 0));
		issue(make_command(lhist_pkg::OP_RECORD, 1, 5, 64'd0, 64'd1, 0));
		issue(make_command(lhist_pkg::OP_RECORD, 1, 5, 64'h8000_0000_0000_0000,
			64'h8000_0000_0000_0003, 0));
		issue(make_command(lhist_pkg::OP_READ, 1, 5, 64'd0, 64'd0, 30));

		// zero divisor acts as one
		write_divisor(16'd0);
		issue(make_command(lhist_pkg::OP_RECORD, 2, 10, 64'd0, 64'd5, 0));
		issue(make_command(lhist_pkg::OP_RECORD, 2, 10, 64'd0, STAMP_MAX, 0));
		issue(make_command(lhist_pkg::OP_READ, 2, 10, 64'd0, 64'd0, 2));

		write_divisor(16'hFFFF);
		issue(make_command(lhist_pkg::OP_RECORD, 2, 10, 64'd0, STAMP_MAX, 0));
		issue(make_command(lhist_pkg::OP_RECORD, 2, 10, 64'd0, 64'd65534, 0));
		issue(make_command(lhist_pkg::OP_RECORD, 2, 10, 64'd0, 64'd131070, 0));
		issue(make_command(lhist_pkg::OP_READ, 2, 10, 64'd0, 64'd0, 30));

		divisors[0] = 16'd1;
		divisors[1] = 16'd0;
		divisors[2] = 16'hFFFF;
		divisors[3] = lhist_pkg::CFG_W'($urandom_range(1, 65535));
		divisors[4] = lhist_pkg::CFG_W'($urandom_range(1, 64));
		divisors[5] = lhist_pkg::CYCLES_PER_US_RESET;
		for (int p = 0; p < 6; p++) begin
			write_divisor(divisors[p]);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// phase 2 runs back to back
				maybe_idle(p != 2);
				issue(random_command());
			end
		end

		drain();
		repeat (80) @(posedge clk);
		if (ledger.errors == 0 && ledger.pending() == 0)
			$display("tb_log2_latency_histogram_unit: PASS");
		else
			$display("tb_log2_latency_histogram_unit: FAIL");
		$finish;
	end

endmodule
